@@ rtl/bw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bw_pkg
// Shared widths, constants and pipeline types for the barycentric weight block.
// ----------------------------------------------------------------------------
package bw_pkg;

	localparam int COORD_BITS = 24;
	localparam int FRAC_BITS  = 24;

	localparam int IN_W    = 24;
	localparam int W_W     = 32;
	localparam int AREA_W  = 52;

	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;

	// quotient bits kept: one above the 32-bit result for saturation
	localparam int QBITS   = W_W + 1;
	localparam int SH      = QBITS - FRAC_BITS;

	localparam int FRONT_STAGES = 6;
	localparam int LATENCY      = FRONT_STAGES + QBITS + 1;

	localparam logic [QBITS-1:0] POS_MAX = QBITS'({1'b0, {(W_W-1){1'b1}}});
	localparam logic [QBITS-1:0] NEG_MAX = QBITS'({1'b1, {(W_W-1){1'b0}}});

	typedef struct packed {
		logic [AREA_W-1:0] rem;
		logic [AREA_W-1:0] den;
		logic [SH-1:0]     nlo;
		logic              neg;
		logic              big;
	} div_in_t;

	typedef struct packed {
		logic [QBITS-1:0] quo;
		logic             neg;
		logic             big;
	} div_out_t;

endpackage

@@ rtl/bw_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bw_front
// Offsets, cross products, area, magnitudes and overflow pre-check (6 stages).
// ----------------------------------------------------------------------------
module bw_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic signed [bw_pkg::IN_W-1:0]      px,
	input  logic signed [bw_pkg::IN_W-1:0]      py,
	input  logic signed [bw_pkg::IN_W-1:0]      ax,
	input  logic signed [bw_pkg::IN_W-1:0]      ay,
	input  logic signed [bw_pkg::IN_W-1:0]      bx,
	input  logic signed [bw_pkg::IN_W-1:0]      by_coord,
	input  logic signed [bw_pkg::IN_W-1:0]      cx,
	input  logic signed [bw_pkg::IN_W-1:0]      cy,
	output logic                                out_valid,
	output logic signed [bw_pkg::AREA_W-1:0]    area,
	output bw_pkg::div_in_t                     div_a,
	output bw_pkg::div_in_t                     div_b,
	output bw_pkg::div_in_t                     div_c
);

	localparam int DW = bw_pkg::DIFF_W;
	localparam int PW = bw_pkg::PROD_W;
	localparam int CW = bw_pkg::CROSS_W;
	localparam int AW = bw_pkg::AREA_W;
	localparam int CB = bw_pkg::COORD_BITS;
	localparam int SH = bw_pkg::SH;

	logic [bw_pkg::FRONT_STAGES-1:0] vld_q;

	logic signed [CB-1:0] px_c, py_c, ax_c, ay_c, bx_c, by_c, cx_c, cy_c;
	logic signed [DW-1:0] dax_s1, day_s1, dbx_s1, dby_s1, dcx_s1, dcy_s1;
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	logic signed [CW-1:0] wa_s3, wb_s3, wc_s3;
	logic signed [CW-1:0] wa_s4, wb_s4, wc_s4;
	logic signed [AW-1:0] area_s4, area_s5, area_s6;
	logic [CW-1:0]        na_s5, nb_s5, nc_s5;
	logic                 sa_s5, sb_s5, sc_s5, sd_s5;
	logic [AW-1:0]        d_s5;

	assign px_c = px[CB-1:0];
	assign py_c = py[CB-1:0];
	assign ax_c = ax[CB-1:0];
	assign ay_c = ay[CB-1:0];
	assign bx_c = bx[CB-1:0];
	assign by_c = by_coord[CB-1:0];
	assign cx_c = cx[CB-1:0];
	assign cy_c = cy[CB-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[bw_pkg::FRONT_STAGES-2:0], in_valid};
		end
	end

	function automatic logic [AW-1:0] mag_of (input logic signed [AW-1:0] v);
		mag_of = v[AW-1] ? AW'(-v) : AW'(v);
	endfunction

	function automatic bw_pkg::div_in_t pre_div (input logic [CW-1:0] n, input logic sn,
		input logic [AW-1:0] d, input logic sd);
		bw_pkg::div_in_t r;
		r.rem = AW'(n >> SH);
		r.den = d;
		r.nlo = n[SH-1:0];
		r.neg = sn ^ sd;
		r.big = ((AW+SH+1)'(n)) >= ((AW+SH+1)'(d) << SH);
		pre_div = r;
	endfunction

	always_ff @(posedge clk) begin
		dax_s1 <= DW'(ax_c) - DW'(px_c);
		day_s1 <= DW'(ay_c) - DW'(py_c);
		dbx_s1 <= DW'(bx_c) - DW'(px_c);
		dby_s1 <= DW'(by_c) - DW'(py_c);
		dcx_s1 <= DW'(cx_c) - DW'(px_c);
		dcy_s1 <= DW'(cy_c) - DW'(py_c);

		p0_s2 <= PW'(dbx_s1) * PW'(dcy_s1);
		p1_s2 <= PW'(dcx_s1) * PW'(dby_s1);
		p2_s2 <= PW'(dcx_s1) * PW'(day_s1);
		p3_s2 <= PW'(dax_s1) * PW'(dcy_s1);
		p4_s2 <= PW'(dax_s1) * PW'(dby_s1);
		p5_s2 <= PW'(dbx_s1) * PW'(day_s1);

		wa_s3 <= CW'(p0_s2) - CW'(p1_s2);
		wb_s3 <= CW'(p2_s2) - CW'(p3_s2);
		wc_s3 <= CW'(p4_s2) - CW'(p5_s2);

		wa_s4   <= wa_s3;
		wb_s4   <= wb_s3;
		wc_s4   <= wc_s3;
		area_s4 <= AW'(wa_s3) + AW'(wb_s3) + AW'(wc_s3);

		na_s5   <= wa_s4[CW-1] ? CW'(-wa_s4) : CW'(wa_s4);
		nb_s5   <= wb_s4[CW-1] ? CW'(-wb_s4) : CW'(wb_s4);
		nc_s5   <= wc_s4[CW-1] ? CW'(-wc_s4) : CW'(wc_s4);
		sa_s5   <= wa_s4[CW-1];
		sb_s5   <= wb_s4[CW-1];
		sc_s5   <= wc_s4[CW-1];
		sd_s5   <= area_s4[AW-1];
		d_s5    <= mag_of(area_s4);
		area_s5 <= area_s4;

		div_a   <= pre_div(na_s5, sa_s5, d_s5, sd_s5);
		div_b   <= pre_div(nb_s5, sb_s5, d_s5, sd_s5);
		div_c   <= pre_div(nc_s5, sc_s5, d_s5, sd_s5);
		area_s6 <= area_s5;
	end

	assign out_valid = vld_q[bw_pkg::FRONT_STAGES-1];
	assign area      = area_s6;

endmodule

@@ rtl/bw_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bw_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bw_div (
	input  logic             clk,
	input  bw_pkg::div_in_t  din,
	output bw_pkg::div_out_t dout
);

	localparam int QB = bw_pkg::QBITS;
	localparam int AW = bw_pkg::AREA_W;
	localparam int SH = bw_pkg::SH;
	localparam int FB = bw_pkg::FRAC_BITS;

	logic [AW-1:0] rem_s [0:QB];
	logic [AW-1:0] den_s [0:QB];
	logic [SH-1:0] nlo_s [0:QB];
	logic [QB-1:0] quo_s [0:QB];
	logic          neg_s [0:QB];
	logic          big_s [0:QB];

	assign rem_s[0] = din.rem;
	assign den_s[0] = din.den;
	assign nlo_s[0] = din.nlo;
	assign quo_s[0] = '0;
	assign neg_s[0] = din.neg;
	assign big_s[0] = din.big;

	for (genvar k = 0; k < QB; k++) begin : g_stage
		localparam int BIT = QB - 1 - k;
		logic          fbit;
		logic [AW:0]   shf;
		logic [AW:0]   dif;

		if (BIT >= FB) begin : g_feed
			assign fbit = nlo_s[k][BIT-FB];
		end else begin : g_zero
			assign fbit = 1'b0;
		end

		assign shf = {rem_s[k], fbit};
		assign dif = shf - {1'b0, den_s[k]};

		always_ff @(posedge clk) begin
			if (shf >= {1'b0, den_s[k]}) begin
				rem_s[k+1] <= dif[AW-1:0];
				quo_s[k+1] <= {quo_s[k][QB-2:0], 1'b1};
			end else begin
				rem_s[k+1] <= shf[AW-1:0];
				quo_s[k+1] <= {quo_s[k][QB-2:0], 1'b0};
			end
			den_s[k+1] <= den_s[k];
			nlo_s[k+1] <= nlo_s[k];
			neg_s[k+1] <= neg_s[k];
			big_s[k+1] <= big_s[k];
		end
	end

	assign dout.quo = quo_s[QB];
	assign dout.neg = neg_s[QB];
	assign dout.big = big_s[QB];

endmodule

@@ rtl/barycentric_weights_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barycentric_weights_top
// Barycentric weights of a query point in a 2D triangle.
// ----------------------------------------------------------------------------
// Use:
//   Drive the point and vertex coordinates with start high for one beat;
//   the beat is taken when busy is low. busy never rises, so a new beat
//   can be taken every cycle.
//   Each beat returns one result beat, marked by done for one cycle:
//   weights in Q7.24, exact twice_area, degenerate and saturated.
//   The path is 6 front stages (offsets, products, cross terms, area,
//   magnitudes, overflow check), 33 divider stages (one quotient bit each,
//   three dividers side by side) and one output stage.
//   Throughput: one beat per cycle.
//   Reset clears all valid bits; beats in flight are dropped and done is
//   low until new beats arrive. The receiver cannot stall; results must be
//   taken in the cycle done is high.
// ----------------------------------------------------------------------------
module barycentric_weights_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [bw_pkg::IN_W-1:0]       px,
	input  logic signed [bw_pkg::IN_W-1:0]       py,
	input  logic signed [bw_pkg::IN_W-1:0]       ax,
	input  logic signed [bw_pkg::IN_W-1:0]       ay,
	input  logic signed [bw_pkg::IN_W-1:0]       bx,
	input  logic signed [bw_pkg::IN_W-1:0]       by_coord,
	input  logic signed [bw_pkg::IN_W-1:0]       cx,
	input  logic signed [bw_pkg::IN_W-1:0]       cy,
	output logic                                 done,
	output logic signed [bw_pkg::W_W-1:0]        weight_a,
	output logic signed [bw_pkg::W_W-1:0]        weight_b,
	output logic signed [bw_pkg::W_W-1:0]        weight_c,
	output logic signed [bw_pkg::AREA_W-1:0]     twice_area,
	output logic                                 degenerate,
	output logic                                 saturated
);

	localparam int QB = bw_pkg::QBITS;
	localparam int AW = bw_pkg::AREA_W;
	localparam int WW = bw_pkg::W_W;

	logic                 fr_valid;
	logic signed [AW-1:0] fr_area;
	bw_pkg::div_in_t      da_in, db_in, dc_in;
	bw_pkg::div_out_t     da_out, db_out, dc_out;

	logic [QB-1:0]        vld_q;
	logic signed [AW-1:0] area_q [0:QB-1];

	logic [WW-1:0]        wa_c, wb_c, wc_c;
	logic                 sa_c, sb_c, sc_c, degen_c;

	assign busy = 1'b0;

	bw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start & ~busy),
		.px        (px),
		.py        (py),
		.ax        (ax),
		.ay        (ay),
		.bx        (bx),
		.by_coord  (by_coord),
		.cx        (cx),
		.cy        (cy),
		.out_valid (fr_valid),
		.area      (fr_area),
		.div_a     (da_in),
		.div_b     (db_in),
		.div_c     (dc_in)
	);

	bw_div u_div_a (.clk(clk), .din(da_in), .dout(da_out));
	bw_div u_div_b (.clk(clk), .din(db_in), .dout(db_out));
	bw_div u_div_c (.clk(clk), .din(dc_in), .dout(dc_out));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[QB-2:0], fr_valid};
		end
	end

	always_ff @(posedge clk) begin
		area_q[0] <= fr_area;
		for (int i = 1; i < QB; i++) begin
			area_q[i] <= area_q[i-1];
		end
	end

	function automatic logic [WW:0] clamp (input bw_pkg::div_out_t d);
		logic [QB-1:0] neg_q;
		neg_q = QB'(-d.quo);
		if (!d.neg) begin
			if (d.big || d.quo > bw_pkg::POS_MAX) clamp = {1'b1, bw_pkg::POS_MAX[WW-1:0]};
			else                                  clamp = {1'b0, d.quo[WW-1:0]};
		end else begin
			if (d.big || d.quo > bw_pkg::NEG_MAX) clamp = {1'b1, bw_pkg::NEG_MAX[WW-1:0]};
			else                                  clamp = {1'b0, neg_q[WW-1:0]};
		end
	endfunction

	always_comb begin
		degen_c      = (area_q[QB-1] == '0);
		{sa_c, wa_c} = clamp(da_out);
		{sb_c, wb_c} = clamp(db_out);
		{sc_c, wc_c} = clamp(dc_out);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_q[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		twice_area <= area_q[QB-1];
		degenerate <= degen_c;
		weight_a   <= degen_c ? '0 : wa_c;
		weight_b   <= degen_c ? '0 : wb_c;
		weight_c   <= degen_c ? '0 : wc_c;
		saturated  <= ~degen_c & (sa_c | sb_c | sc_c);
	end

endmodule

@@ rtl/bw_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bw_checker
// Port-level checks for barycentric_weights_top, bound to the top level.
// ----------------------------------------------------------------------------
module bw_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic signed [bw_pkg::W_W-1:0]     weight_a,
	input logic signed [bw_pkg::W_W-1:0]     weight_b,
	input logic signed [bw_pkg::W_W-1:0]     weight_c,
	input logic signed [bw_pkg::AREA_W-1:0]  twice_area,
	input logic                              degenerate,
	input logic                              saturated
);

	localparam logic [bw_pkg::W_W-1:0] WMAX = {1'b0, {(bw_pkg::W_W-1){1'b1}}};
	localparam logic [bw_pkg::W_W-1:0] WMIN = {1'b1, {(bw_pkg::W_W-1){1'b0}}};

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, bw_pkg::LATENCY))
		else $error("result beat without matching input beat");

	a_degen_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (degenerate == (twice_area == '0)))
		else $error("degenerate flag does not match area");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && degenerate) |-> (weight_a == '0 && weight_b == '0 && weight_c == '0
			&& !saturated))
		else $error("degenerate beat with nonzero weights");

	a_sat_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |-> (weight_a == WMAX || weight_a == WMIN ||
			weight_b == WMAX || weight_b == WMIN || weight_c == WMAX || weight_c == WMIN))
		else $error("saturated beat without clamped weight");

endmodule

bind barycentric_weights_top bw_checker u_bw_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.weight_a   (weight_a),
	.weight_b   (weight_b),
	.weight_c   (weight_c),
	.twice_area (twice_area),
	.degenerate (degenerate),
	.saturated  (saturated)
);

@@ dv/bw_weight_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bw_weight_checker
// Watches the command and result ports of the barycentric weight block,
// computes the weights and twice area of every accepted beat in exact
// integer arithmetic and compares each result beat, field by field, with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bw_weight_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic                                 busy,
	input  logic signed [bw_pkg::IN_W-1:0]       px,
	input  logic signed [bw_pkg::IN_W-1:0]       py,
	input  logic signed [bw_pkg::IN_W-1:0]       ax,
	input  logic signed [bw_pkg::IN_W-1:0]       ay,
	input  logic signed [bw_pkg::IN_W-1:0]       bx,
	input  logic signed [bw_pkg::IN_W-1:0]       by_coord,
	input  logic signed [bw_pkg::IN_W-1:0]       cx,
	input  logic signed [bw_pkg::IN_W-1:0]       cy,
	input  logic                                 done,
	input  logic signed [bw_pkg::W_W-1:0]        weight_a,
	input  logic signed [bw_pkg::W_W-1:0]        weight_b,
	input  logic signed [bw_pkg::W_W-1:0]        weight_c,
	input  logic signed [bw_pkg::AREA_W-1:0]     twice_area,
	input  logic                                 degenerate,
	input  logic                                 saturated,
	output int                                   errors,
	output int                                   pending,
	output int                                   n_results,
	output int                                   n_degenerate,
	output int                                   n_saturated
);

	typedef struct packed {
		logic [bw_pkg::W_W-1:0]    wa;
		logic [bw_pkg::W_W-1:0]    wb;
		logic [bw_pkg::W_W-1:0]    wc;
		logic [bw_pkg::AREA_W-1:0] area;
		logic                      degen;
		logic                      sat;
	} weights_t;

	weights_t expected_weights[$];

	// (num * 2^FRAC_BITS) / den, truncated toward zero, clamped to 32 bits
	function automatic logic [bw_pkg::W_W-1:0] scaled_quotient(longint num, longint den,
		inout bit sat);
		logic [127:0] n, d, q;
		bit           neg;
		neg = (num < 0) != (den < 0);
		n   = 128'(num < 0 ? -num : num);
		d   = 128'(den < 0 ? -den : den);
		q   = (n << bw_pkg::FRAC_BITS) / d;
		if (!neg) begin
			if (q > 128'h7FFF_FFFF) begin
				sat = 1'b1;
				return 32'h7FFF_FFFF;
			end
			return q[bw_pkg::W_W-1:0];
		end
		if (q > 128'h8000_0000) begin
			sat = 1'b1;
			return 32'h8000_0000;
		end
		return -q[bw_pkg::W_W-1:0];
	endfunction

	function automatic weights_t triangle_weights(
		logic signed [bw_pkg::IN_W-1:0] qx, logic signed [bw_pkg::IN_W-1:0] qy,
		logic signed [bw_pkg::IN_W-1:0] x0, logic signed [bw_pkg::IN_W-1:0] y0,
		logic signed [bw_pkg::IN_W-1:0] x1, logic signed [bw_pkg::IN_W-1:0] y1,
		logic signed [bw_pkg::IN_W-1:0] x2, logic signed [bw_pkg::IN_W-1:0] y2);
		longint   dax, day, dbx, dby, dcx, dcy, ca, cb, cc, area;
		bit       sat;
		weights_t r;
		dax  = longint'(x0) - longint'(qx);
		day  = longint'(y0) - longint'(qy);
		dbx  = longint'(x1) - longint'(qx);
		dby  = longint'(y1) - longint'(qy);
		dcx  = longint'(x2) - longint'(qx);
		dcy  = longint'(y2) - longint'(qy);
		ca   = dbx * dcy - dcx * dby;
		cb   = dcx * day - dax * dcy;
		cc   = dax * dby - dbx * day;
		area = ca + cb + cc;
		sat  = 1'b0;
		r    = '0;
		r.area = area[bw_pkg::AREA_W-1:0];
		if (area == 0) begin
			r.degen = 1'b1;
			return r;
		end
		r.wa  = scaled_quotient(ca, area, sat);
		r.wb  = scaled_quotient(cb, area, sat);
		r.wc  = scaled_quotient(cc, area, sat);
		r.sat = sat;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		weights_t e;
		if (!arst_n) begin
			expected_weights.delete();
			errors       <= 0;
			pending      <= 0;
			n_results    <= 0;
			n_degenerate <= 0;
			n_saturated  <= 0;
		end else begin
			if (done) begin
				n_results <= n_results + 1;
				if (expected_weights.size() == 0) begin
					$error("result beat with no beat outstanding");
					errors <= errors + 1;
				end else begin
					e = expected_weights.pop_front();
					if (e.degen) n_degenerate <= n_degenerate + 1;
					if (e.sat)   n_saturated  <= n_saturated + 1;
					if (weight_a !== e.wa || weight_b !== e.wb || weight_c !== e.wc ||
					    twice_area !== e.area || degenerate !== e.degen ||
					    saturated !== e.sat)
						errors <= errors + 1;
					if (weight_a !== e.wa)
						$error("weight_a expected %0d got %0d", $signed(e.wa), weight_a);
					if (weight_b !== e.wb)
						$error("weight_b expected %0d got %0d", $signed(e.wb), weight_b);
					if (weight_c !== e.wc)
						$error("weight_c expected %0d got %0d", $signed(e.wc), weight_c);
					if (twice_area !== e.area)
						$error("twice_area expected %0d got %0d", $signed(e.area), twice_area);
					if (degenerate !== e.degen)
						$error("degenerate expected %0b got %0b", e.degen, degenerate);
					if (saturated !== e.sat)
						$error("saturated expected %0b got %0b", e.sat, saturated);
				end
			end
			if (start && !busy)
				expected_weights.push_back(triangle_weights(px, py, ax, ay, bx, by_coord, cx, cy));
			pending <= expected_weights.size();
		end
	end

endmodule

@@ dv/tb_barycentric_weights_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_barycentric_weights_top
// Drives the barycentric weight block with directed corner triangles and
// random points and triangles in bursts with random gaps; the checker beside
// the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_barycentric_weights_top;

	localparam int N_RANDOM = 480;
	localparam int WDOG_MAX = 2000;
	localparam int CMAX     = 8388607;
	localparam int CMIN     = -8388608;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 start;
	logic                                 busy;
	logic                                 busy_seen;
	logic signed [bw_pkg::IN_W-1:0]       px, py, ax, ay, bx, by_coord, cx, cy;
	logic                                 done;
	logic signed [bw_pkg::W_W-1:0]        weight_a, weight_b, weight_c;
	logic signed [bw_pkg::AREA_W-1:0]     twice_area;
	logic                                 degenerate, saturated;
	int                                   errors, pending, n_results, n_degenerate, n_saturated;
	int                                   idle_cycles;
	int                                   n_sent;

	barycentric_weights_top i_dut (.*);

	bw_weight_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk) busy_seen <= busy;

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("watchdog expired after %0d idle cycles", idle_cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_beat(int qx, int qy, int x0, int y0, int x1, int y1, int x2, int y2);
		start    <= 1'b1;
		px       <= qx[bw_pkg::IN_W-1:0];
		py       <= qy[bw_pkg::IN_W-1:0];
		ax       <= x0[bw_pkg::IN_W-1:0];
		ay       <= y0[bw_pkg::IN_W-1:0];
		bx       <= x1[bw_pkg::IN_W-1:0];
		by_coord <= y1[bw_pkg::IN_W-1:0];
		cx       <= x2[bw_pkg::IN_W-1:0];
		cy       <= y2[bw_pkg::IN_W-1:0];
		do @(posedge clk); while (busy_seen);
		n_sent++;
	endtask

	task automatic idle_gap(int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	function automatic int rnd_coord();
		return int'($signed($urandom_range(0, 32'hFFFFFF) << 8)) >>> 8;
	endfunction

	function automatic int clamp24(int v);
		if (v > CMAX) return CMAX;
		if (v < CMIN) return CMIN;
		return v;
	endfunction

	task automatic random_beat();
		int kind, ox, oy, sz, x0, y0, x1, y1, x2, y2;
		kind = $urandom_range(0, 9);
		if (kind < 2) begin
			send_beat(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
			          rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
			return;
		end
		sz = (kind < 5) ? (1 << $urandom_range(0, 22)) : (1 << $urandom_range(0, 8));
		ox = rnd_coord() >>> 1;
		oy = rnd_coord() >>> 1;
		x0 = clamp24(ox + $signed($urandom_range(0, 2 * sz)) - sz);
		y0 = clamp24(oy + $signed($urandom_range(0, 2 * sz)) - sz);
		x1 = clamp24(ox + $signed($urandom_range(0, 2 * sz)) - sz);
		y1 = clamp24(oy + $signed($urandom_range(0, 2 * sz)) - sz);
		x2 = clamp24(ox + $signed($urandom_range(0, 2 * sz)) - sz);
		y2 = clamp24(oy + $signed($urandom_range(0, 2 * sz)) - sz);
		if (kind == 9) begin
			// collinear third vertex
			x2 = clamp24(2 * x1 - x0);
			y2 = clamp24(2 * y1 - y0);
		end
		if (kind == 8)
			// far point for weight clamping
			send_beat(rnd_coord(), rnd_coord(), x0, y0, x1, y1, x2, y2);
		else
			send_beat(clamp24(ox + $signed($urandom_range(0, 4 * sz)) - 2 * sz),
			          clamp24(oy + $signed($urandom_range(0, 4 * sz)) - 2 * sz),
			          x0, y0, x1, y1, x2, y2);
	endtask

	initial begin
		int burst;
		int total_errors;
		start = 1'b0;
		{px, py, ax, ay, bx, by_coord, cx, cy} = '0;
		n_sent      = 0;
		arst_n      = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(0, 0, 0, 0, 0, 0, 0, 0);
		send_beat(5, 5, 0, 0, 10, 10, 20, 20);
		send_beat(0, 0, 0, 0, 1 << 10, 0, 0, 1 << 10);
		send_beat(1 << 10, 0, 0, 0, 1 << 10, 0, 0, 1 << 10);
		send_beat(100, 100, 0, 0, 0, 300, 300, 0);
		send_beat(-500, -500, 0, 0, 300, 0, 0, 300);
		idle_gap(3);
		send_beat(CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX);
		send_beat(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX);
		send_beat(0, 0, CMAX, CMAX, CMIN, CMAX, CMIN, CMIN);
		send_beat(CMIN, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX);
		send_beat(CMAX, CMAX, 0, 0, 1, 0, 0, 1);
		send_beat(CMIN, CMIN, 0, 0, 0, 1, 1, 0);
		send_beat(-1, -1, -1, -1, -1, -1, -1, -1);
		send_beat(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN);
		idle_gap(1);
		send_beat(1, 1, 0, 0, 3, 0, 0, 3);
		send_beat(0, 0, -7, -3, 11, -5, 2, 13);
		send_beat(3, 1, 0, 0, 1, 0, 0, 1);
		send_beat(0, 1, 0, 0, 2, 0, 0, 2);

		while (n_sent < N_RANDOM + 18) begin
			burst = $urandom_range(1, 30);
			repeat (burst) random_beat();
			if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 15));
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (bw_pkg::LATENCY + 10) @(posedge clk);
		total_errors = errors;
		if (pending != 0) total_errors++;

		$display("%0d beats sent, %0d results checked", n_sent, n_results);
		$display("%0d degenerate, %0d with clamped weights", n_degenerate, n_saturated);
		if (total_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
